// ===== rtl/sum_of_two_squares_test_assert.svh =====
// assertion macros for the sum of two squares test block
`ifndef SUM_OF_TWO_SQUARES_TEST_ASSERT_SVH
`define SUM_OF_TWO_SQUARES_TEST_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent holds, consequent holds in the same cycle
`define SOTS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sots assertion failed");
// antecedent holds, consequent holds in the next cycle
`define SOTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sots assertion failed");
`else
`define SOTS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define SOTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/sots_pkg.sv =====
// shared types and defaults for the sum of two squares test block
package sots_pkg;

  localparam int VALUE_BITS_DEF = 31;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SQRT = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

endpackage

// ===== rtl/sum_of_two_squares_test.sv =====
// sum of two squares test: one value in, one is_sum flag out per item
// each item runs the root digit steps in ST_SQRT, then the two-pointer scan in ST_SCAN, then sets out_valid
// in_ready is high only in idle, so a new value is taken only once the last result is in out_valid
// a stalled result holds the sequencer in the scan until out_valid can be refilled
// root digit steps and two-pointer steps share one add/subtract unit, one step per cycle
// rst_n is synchronous active low and clears the sequencer and output valid
`include "sum_of_two_squares_test_assert.svh"

module sum_of_two_squares_test #(
  parameter int VALUE_BITS = sots_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_is_sum
);

  localparam int W    = VALUE_BITS + 2;
  localparam int HB   = (VALUE_BITS + 1) / 2 + 1;
  localparam int TOPK = (VALUE_BITS - 1) / 2;
  localparam int CB   = $clog2(TOPK + 1);

  sots_pkg::state_t state_r, state_nxt;

  logic [W-1:0]          acc_r, acc_nxt;
  logic [VALUE_BITS-1:0] res_r, res_nxt;
  logic [HB-1:0]         lo_r, lo_nxt;
  logic [HB-1:0]         hi_r, hi_nxt;
  logic [CB-1:0]         cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_sum_r, out_is_sum_nxt;

  // shared add/subtract unit
  logic [W-1:0] au_a, au_b, au_sum;
  logic         au_sub;

  logic [VALUE_BITS-1:0] bitv;
  logic [VALUE_BITS-1:0] res_shift;
  logic [VALUE_BITS-1:0] res_new;
  logic [HB-1:0]         hi_dec;
  logic                  take;
  logic                  out_free;
  logic                  fin;
  logic                  fin_val;
  logic                  in_fire;

  assign in_ready   = (state_r == sots_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_is_sum = out_is_sum_r;
  assign out_free   = !out_valid_r || out_ready;

  assign au_sum = au_a + (au_b ^ {W{au_sub}}) + W'(au_sub);

  assign bitv      = {{(VALUE_BITS-1){1'b0}}, 1'b1} << {cnt_r, 1'b0};
  assign res_shift = res_r >> 1;
  assign take      = !au_sum[W-1];
  // root bits sit above the current digit, so or is the add
  assign res_new   = take ? (res_shift | bitv) : res_shift;
  assign hi_dec    = hi_r - HB'(1);

  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_is_sum_nxt = out_is_sum_r;
    au_a           = acc_r;
    au_b           = '0;
    au_sub         = 1'b1;
    fin            = 1'b0;
    fin_val        = 1'b0;
    case (state_r)
      sots_pkg::ST_IDLE: begin
        if (in_fire) begin
          acc_nxt   = {2'b00, in_value};
          res_nxt   = '0;
          cnt_nxt   = CB'(TOPK);
          state_nxt = sots_pkg::ST_SQRT;
        end
      end
      sots_pkg::ST_SQRT: begin
        au_b    = {2'b00, res_r | bitv};
        au_sub  = 1'b1;
        res_nxt = res_new;
        if (take) begin
          acc_nxt = au_sum;
        end
        cnt_nxt = cnt_r - CB'(1);
        if (cnt_r == '0) begin
          // acc now holds value - root^2, the gap for lo = 0, hi = root
          hi_nxt    = res_new[HB-1:0];
          lo_nxt    = '0;
          state_nxt = sots_pkg::ST_SCAN;
        end
      end
      sots_pkg::ST_SCAN: begin
        // acc holds value - (lo^2 + hi^2)
        if (lo_r > hi_r) begin
          fin = 1'b1;
        end else if (acc_r == '0) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else if (!acc_r[W-1]) begin
          au_b    = {{(W-HB-1){1'b0}}, lo_r, 1'b1};
          au_sub  = 1'b1;
          acc_nxt = au_sum;
          lo_nxt  = lo_r + HB'(1);
        end else if (hi_r == '0) begin
          fin = 1'b1;
        end else begin
          au_b    = {{(W-HB-1){1'b0}}, hi_dec, 1'b1};
          au_sub  = 1'b0;
          acc_nxt = au_sum;
          hi_nxt  = hi_dec;
        end
        if (fin && out_free) begin
          out_valid_nxt  = 1'b1;
          out_is_sum_nxt = fin_val;
          state_nxt      = sots_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sots_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sots_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    res_r        <= res_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cnt_r        <= cnt_nxt;
    out_is_sum_r <= out_is_sum_nxt;
  end

  `SOTS_ASSERT_NEXT(a_fire_starts_root, clk, rst_n, in_fire, state_r == sots_pkg::ST_SQRT)
  `SOTS_ASSERT_SAME(a_root_rem_nonneg, clk, rst_n, state_r == sots_pkg::ST_SQRT, !acc_r[W-1])
  `SOTS_ASSERT_NEXT(a_root_to_scan, clk, rst_n, state_r == sots_pkg::ST_SQRT, state_r == sots_pkg::ST_SQRT || state_r == sots_pkg::ST_SCAN)
  `SOTS_ASSERT_SAME(a_result_from_scan, clk, rst_n, $rose(out_valid_r), $past(state_r == sots_pkg::ST_SCAN))

endmodule

// ===== tb/sum_of_two_squares_test_tb.sv =====
// self-checking testbench for the sum of two squares test block
module sum_of_two_squares_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = sots_pkg::VALUE_BITS_DEF;
  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 200;

  class flag_scoreboard;
    bit expected_flags[$];
    longint unsigned expected_values[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // exact floor square root, digit by digit
    static function longint unsigned root_floor(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned bitv = 64'h1 << 62;
      longint unsigned x = v;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // two-pointer scan from (0, root) until a match is found or the pointers cross
    static function bit predict_is_sum(longint unsigned v);
      longint unsigned lo = 0;
      longint unsigned hi = root_floor(v);
      longint unsigned s;
      while (lo <= hi) begin
        s = lo * lo + hi * hi;
        if (s == v) return 1'b1;
        if (s < v) begin
          lo++;
        end else begin
          if (hi == 0) break;
          hi--;
        end
      end
      return 1'b0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task note_input(logic [VB-1:0] v);
      expected_values.push_back(longint'(v));
      expected_flags.push_back(predict_is_sum(longint'(v)));
    endtask

    task check_result(logic got);
      bit want;
      longint unsigned v;
      if (expected_flags.size() == 0) begin
        report_mismatch($sformatf("result beat is_sum=%0b with no input pending", got));
      end else begin
        want = expected_flags.pop_front();
        v = expected_values.pop_front();
        if (got !== want)
          report_mismatch($sformatf("value %0d expected is_sum %0b got %0b", v, want, got));
      end
    endtask

    function int pending();
      return expected_flags.size();
    endfunction

    task close_out();
      while (expected_flags.size() != 0) begin
        report_mismatch($sformatf("no result for value %0d", expected_values.pop_front()));
        void'(expected_flags.pop_front());
      end
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [VB-1:0] in_value;
  logic          out_valid;
  logic          out_ready;
  logic          out_is_sum;

  flag_scoreboard sb = new();

  bit hold_req;
  int hold_left;
  int rcv_cycle;
  int burst_left;
  int quiet_cycles;

  longint unsigned directed_vals[] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 21, 25, 50, 325,
    2147483647, 2147483646, 1073741824, 1073741823,
    2147395600, 2147395601, 1431655765, 715827882
  };

  sum_of_two_squares_test #(
    .VALUE_BITS(VB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_is_sum(out_is_sum)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // offer one beat, hold it until accepted, then pace the burst
  task automatic offer(input logic [VB-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(v);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_value <= VB'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  function automatic logic [VB-1:0] random_value();
    int kind;
    longint unsigned a;
    longint unsigned b;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      a = 64'($urandom_range(0, 255));
      b = 64'($urandom_range(0, 255));
      return VB'(a * a + b * b);
    end else if (kind < 75) begin
      return VB'($urandom_range(0, 65535));
    end else if (kind < 92) begin
      return VB'($urandom_range(0, (1 << 20) - 1));
    end else if (kind < 96) begin
      return VB'($urandom);
    end else begin
      // large sum that still fits the field
      a = 64'($urandom_range(0, 46340));
      b = 64'($urandom_range(0, 46340));
      while (a * a + b * b > 64'd2147483647) b = b >> 1;
      return VB'(a * a + b * b);
    end
  endfunction

  // receiver: rotating stall pattern plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    rcv_cycle = 0;
    forever begin
      @(posedge clk);
      rcv_cycle++;
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rcv_cycle[8:7])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= 1'($urandom_range(0, 1));
          2'd2: out_ready <= (rcv_cycle[1:0] == 2'd0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_is_sum);
  end

  // watchdog on cycles with no beat on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sum_of_two_squares_test_tb failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    hold_req = 1'b0;
    burst_left = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vals[i]) offer(directed_vals[i][VB-1:0]);
    // all-ones is already covered by the largest value above

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) offer(VB'($urandom_range(0, 4095)));

    for (int i = 0; i < 66; i++) offer(random_value());

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("sum_of_two_squares_test_tb passed");
    end else begin
      $display("sum_of_two_squares_test_tb failed");
    end
    $finish;
  end

endmodule
